@@ hw/rtl/dcbs_pkg.sv @@
// ----------------------------------------------------------------------------
// dcbs_pkg: shared types and constants for the bit-pair sender
// Holds the beat payload structs, the sender state record and the tick marks
// of the bus timing sequence.
// ----------------------------------------------------------------------------
package dcbs_pkg;

    localparam int TickWidth = 6;

    typedef logic [TickWidth-1:0] tick_t;

    localparam tick_t T_DATA_RELEASE = 6'd15;
    localparam tick_t T_PAIR_A       = 6'd19;
    localparam tick_t T_PAIR_B       = 6'd27;
    localparam tick_t T_PAIR_C       = 6'd35;
    localparam tick_t T_PAIR_D       = 6'd43;
    localparam tick_t T_DATA_FREE    = 6'd51;
    localparam tick_t T_ACK          = 6'd56;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_SEND = 2'd2
    } phase_t;

    typedef struct packed {
        logic       start_req;
        logic [7:0] byte_value;
        logic       data_line_in;
        logic       atn_line_in;
        logic       reset_idle;
    } dcbs_in_t;

    typedef struct packed {
        logic clk_drive;
        logic data_drive;
        logic busy_res;
        logic finished;
        logic acknowledged;
        logic aborted;
    } dcbs_out_t;

    typedef struct packed {
        phase_t     phase;
        tick_t      tick_count;
        logic [7:0] held_byte;
        logic       clk_level;
        logic       data_level;
    } dcbs_state_t;

endpackage

@@ hw/rtl/dcbs_step.sv @@
// ----------------------------------------------------------------------------
// dcbs_step: one tick of the sender sequence
// Combinational next state and result for one input beat, given the current
// sender state.
// ----------------------------------------------------------------------------
module dcbs_step (
    input  dcbs_pkg::dcbs_state_t state,
    input  dcbs_pkg::dcbs_in_t    item,
    output dcbs_pkg::dcbs_state_t state_next,
    output dcbs_pkg::dcbs_out_t   result
);

    always_comb
    begin
        dcbs_pkg::dcbs_state_t s;
        dcbs_pkg::tick_t       t;
        logic                  fin;
        logic                  ack;
        logic                  abrt;

        s    = state;
        fin  = 1'b0;
        ack  = 1'b0;
        abrt = 1'b0;
        t    = s.tick_count + 6'd1;

        // Idle: latch the byte on start, then run the wait check on this same tick
        if (s.phase != dcbs_pkg::PH_WAIT && s.phase != dcbs_pkg::PH_SEND)
        begin
            s.phase = dcbs_pkg::PH_IDLE;
            if (item.start_req)
            begin
                s.held_byte = item.byte_value;
                s.phase     = dcbs_pkg::PH_WAIT;
            end
        end

        case (s.phase)
            dcbs_pkg::PH_WAIT:
            begin
                if (item.data_line_in)
                begin
                    s.phase      = dcbs_pkg::PH_SEND;
                    s.tick_count = '0;
                    s.data_level = 1'b0;
                end
                else if (!item.atn_line_in || !item.reset_idle)
                begin
                    s.phase      = dcbs_pkg::PH_IDLE;
                    s.tick_count = '0;
                    fin          = 1'b1;
                    abrt         = 1'b1;
                end
            end
            dcbs_pkg::PH_SEND:
            begin
                s.tick_count = t;
                // Pairs go out inverted: CLK/DATA from bits 7/5, 6/4, 3/1, 2/0
                case (t)
                    dcbs_pkg::T_DATA_RELEASE: s.data_level = 1'b1;
                    dcbs_pkg::T_PAIR_A:
                    begin
                        s.clk_level  = ~s.held_byte[7];
                        s.data_level = ~s.held_byte[5];
                    end
                    dcbs_pkg::T_PAIR_B:
                    begin
                        s.clk_level  = ~s.held_byte[6];
                        s.data_level = ~s.held_byte[4];
                    end
                    dcbs_pkg::T_PAIR_C:
                    begin
                        s.clk_level  = ~s.held_byte[3];
                        s.data_level = ~s.held_byte[1];
                    end
                    dcbs_pkg::T_PAIR_D:
                    begin
                        s.clk_level  = ~s.held_byte[2];
                        s.data_level = ~s.held_byte[0];
                    end
                    dcbs_pkg::T_DATA_FREE: s.data_level = 1'b1;
                    dcbs_pkg::T_ACK:
                    begin
                        fin          = 1'b1;
                        ack          = item.data_line_in;
                        s.phase      = dcbs_pkg::PH_IDLE;
                        s.tick_count = '0;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        state_next          = s;
        result.clk_drive    = s.clk_level;
        result.data_drive   = s.data_level;
        result.busy_res     = (s.phase == dcbs_pkg::PH_WAIT) || (s.phase == dcbs_pkg::PH_SEND);
        result.finished     = fin;
        result.acknowledged = ack;
        result.aborted      = abrt;
    end

endmodule

@@ hw/rtl/drive_clocked_bitpair_sender_core.sv @@
// ----------------------------------------------------------------------------
// drive_clocked_bitpair_sender_core: drive-clocked bit-pair byte sender
// Input register, one-tick sequencer step and result register.
// ----------------------------------------------------------------------------
// Usage:
//   Each input beat on in_data is one microsecond tick: a start request with
//   its byte plus the sensed DATA, ATN and bus reset lines. Every input beat
//   yields exactly one result beat on out_data with the CLK/DATA levels to
//   drive, the busy flag and, on the tick an attempt ends, finished with
//   acknowledged or aborted.
//   Path: input register, sequencer step, result register. Throughput: one
//   beat per cycle while out_ready is high; the sequencer step is a single
//   pass of logic between the input and result registers.
//   Stall: when out_ready is low the result register holds; the input
//   register still takes a beat only if it is empty, after which in_ready
//   drops until the result is taken. No beat is lost or repeated.
//   Reset: both registers empty, sequencer idle, CLK and DATA released.
// ----------------------------------------------------------------------------
module drive_clocked_bitpair_sender_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  dcbs_pkg::dcbs_in_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output dcbs_pkg::dcbs_out_t out_data
);

    logic                  in_valid_reg;
    dcbs_pkg::dcbs_in_t    in_reg;
    logic                  out_valid_reg;
    dcbs_pkg::dcbs_out_t   out_reg;
    dcbs_pkg::dcbs_state_t state_reg;
    dcbs_pkg::dcbs_state_t state_next;
    dcbs_pkg::dcbs_out_t   out_next;
    logic                  advance;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    dcbs_step u_step (
        .state      (state_reg),
        .item       (in_reg),
        .state_next (state_next),
        .result     (out_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg         <= 1'b0;
            out_valid_reg        <= 1'b0;
            state_reg.phase      <= dcbs_pkg::PH_IDLE;
            state_reg.tick_count <= '0;
            state_reg.held_byte  <= '0;
            state_reg.clk_level  <= 1'b1;
            state_reg.data_level <= 1'b1;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            // Advance the sequencer only when its result has a place to go
            if (advance)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg <= in_data;
        end
        if (advance)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_ack_needs_finish: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.acknowledged |-> out_reg.finished)
        else $error("acknowledge without finish");

    a_abort_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.aborted |-> out_reg.finished && !out_reg.acknowledged)
        else $error("abort without finish or with acknowledge");

    a_finish_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.finished |-> !out_reg.busy_res)
        else $error("finished beat still busy");

    a_data_held_low: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase == dcbs_pkg::PH_SEND && state_reg.tick_count < dcbs_pkg::T_DATA_RELEASE
        |-> !state_reg.data_level)
        else $error("DATA released early in the send");

    a_idle_without_input: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(state_reg))
        else $error("sequencer moved without an input beat");

endmodule
